[sv/cfus_pkg.sv]
`timescale 1ns / 1ps

package cfus_pkg;

    // buffer size and header length
    localparam int PAYLOAD_MAX  = 4096;
    localparam int ADDR_W       = $clog2(PAYLOAD_MAX);
    localparam int HEADER_BYTES = 12;

    // field widths
    localparam int LEN_W = 13;
    localparam int ID_W  = 16;

    // configuration register indexes
    localparam logic REG_PAYLOAD_LENGTH = 1'b0;
    localparam logic REG_MAX_CHUNK      = 1'b1;
    localparam logic [LEN_W-1:0] MAX_CHUNK_RESET = 13'd512;

    // phase codes as seen on the phase port
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT_OPEN  = 3'd1;
    localparam logic [2:0] PH_HEADER     = 3'd2;
    localparam logic [2:0] PH_DATA       = 3'd3;
    localparam logic [2:0] PH_WAIT_ACK   = 3'd4;
    localparam logic [2:0] PH_WAIT_FINAL = 3'd5;
    localparam logic [2:0] PH_OK         = 3'd6;
    localparam logic [2:0] PH_FAILED     = 3'd7;

    // error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_NO_RESPONSE  = 3'd1;
    localparam logic [2:0] ERR_CREATE       = 3'd2;
    localparam logic [2:0] ERR_UNEXPECTED   = 3'd3;
    localparam logic [2:0] ERR_PKT_TIMEOUT  = 3'd4;
    localparam logic [2:0] ERR_BAD_ACK      = 3'd5;
    localparam logic [2:0] ERR_COMPLETION   = 3'd6;

    // response codes from the display
    localparam logic [7:0] RSP_OPEN     = 8'hFE;
    localparam logic [7:0] RSP_CREATE_F = 8'h06;
    localparam logic [7:0] RSP_ACK      = 8'h05;
    localparam logic [7:0] RSP_NAK      = 8'h04;
    localparam logic [7:0] RSP_DONE     = 8'hFD;

    // request codes on req_type
    localparam logic [2:0] REQ_LOAD    = 3'd0;
    localparam logic [2:0] REQ_START   = 3'd1;
    localparam logic [2:0] REQ_SLOT    = 3'd2;
    localparam logic [2:0] REQ_RESP    = 3'd3;
    localparam logic [2:0] REQ_TIMEOUT = 3'd4;

    // classified command held in the queue
    typedef enum logic [2:0] {
        CMD_LOAD,
        CMD_START,
        CMD_SLOT,
        CMD_RESP,
        CMD_TIMEOUT,
        CMD_NONE
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0] payload_length;
        logic [LEN_W-1:0] max_chunk;
    } cfg_t;

    // byte of the packet header at a given position
    function automatic logic [7:0] header_byte(
        input logic [3:0]       pos,
        input logic [ID_W-1:0]  id,
        input logic [LEN_W-1:0] chunk
    );
        logic [7:0] b;
        case (pos)
            4'd0:    b = 8'h3A;
            4'd1:    b = 8'hA1;
            4'd2:    b = 8'hBB;
            4'd3:    b = 8'h44;
            4'd4:    b = 8'h7F;
            4'd5:    b = 8'hFF;
            4'd6:    b = 8'hFE;
            4'd7:    b = 8'h00;
            4'd8:    b = id[7:0];
            4'd9:    b = id[15:8];
            4'd10:   b = chunk[7:0];
            default: b = {3'b000, chunk[12:8]};
        endcase
        return b;
    endfunction

endpackage

[sv/cfus_front.sv]
`timescale 1ns / 1ps

module cfus_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          req_type,
    input  logic [7:0]          data_byte,
    output logic                item_valid,
    output cfus_pkg::item_t     item,
    input  logic                item_pop
);

    cfus_pkg::item_t fifo_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    logic            pop;
    cfus_pkg::item_t decoded;

    // classify the request
    always_comb
    begin
        decoded.data = data_byte;
        unique case (req_type)
            cfus_pkg::REQ_LOAD:    decoded.cmd = cfus_pkg::CMD_LOAD;
            cfus_pkg::REQ_START:   decoded.cmd = cfus_pkg::CMD_START;
            cfus_pkg::REQ_SLOT:    decoded.cmd = cfus_pkg::CMD_SLOT;
            cfus_pkg::REQ_RESP:    decoded.cmd = cfus_pkg::CMD_RESP;
            cfus_pkg::REQ_TIMEOUT: decoded.cmd = cfus_pkg::CMD_TIMEOUT;
            default:               decoded.cmd = cfus_pkg::CMD_NONE;
        endcase
    end

    // two-entry queue towards the back end
    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign item_valid = (count_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[sv/cfus_back.sv]
`timescale 1ns / 1ps

module cfus_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfus_pkg::cfg_t                cfg,
    input  logic                          item_valid,
    input  cfus_pkg::item_t               item,
    output logic                          item_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          tx_valid,
    output logic [7:0]                    tx_byte,
    output logic [2:0]                    phase,
    output logic [2:0]                    error_code,
    output logic [cfus_pkg::ID_W-1:0]     packet_number,
    output logic [cfus_pkg::LEN_W-1:0]    bytes_acked,
    output logic                          finished
);

    typedef enum logic [2:0] {
        S_IDLE       = cfus_pkg::PH_IDLE,
        S_WAIT_OPEN  = cfus_pkg::PH_WAIT_OPEN,
        S_HEADER     = cfus_pkg::PH_HEADER,
        S_DATA       = cfus_pkg::PH_DATA,
        S_WAIT_ACK   = cfus_pkg::PH_WAIT_ACK,
        S_WAIT_FINAL = cfus_pkg::PH_WAIT_FINAL,
        S_OK         = cfus_pkg::PH_OK,
        S_FAILED     = cfus_pkg::PH_FAILED
    } state_t;

    localparam int LW = cfus_pkg::LEN_W;
    localparam int AW = cfus_pkg::ADDR_W;
    localparam logic [LW-1:0] LEN_CAP = LW'(cfus_pkg::PAYLOAD_MAX);
    localparam logic [LW-1:0] HDR_LEN = LW'(cfus_pkg::HEADER_BYTES);

    state_t                   state_reg, state_next;
    logic [LW-1:0]            load_count_reg, load_count_next;
    logic [cfus_pkg::ID_W-1:0] packet_id_reg, packet_id_next;
    logic [LW-1:0]            send_offset_reg, send_offset_next;
    logic [LW-1:0]            byte_pos_reg, byte_pos_next;
    logic [LW-1:0]            chunk_reg, chunk_next;
    logic [2:0]               error_reg, error_next;

    // result register
    logic                     out_valid_reg;
    logic                     tx_valid_reg, tx_valid_next;
    logic [7:0]               tx_byte_reg, tx_byte_next;
    logic                     use_mem_reg, use_mem_next;

    // payload buffer
    logic [7:0]               mem [cfus_pkg::PAYLOAD_MAX];
    logic [7:0]               mem_q_reg;
    logic                     mem_wr;
    logic                     mem_rd;
    logic [AW-1:0]            mem_rd_addr;

    logic                     fire;
    logic                     at_rest;
    logic [LW-1:0]            len_eff;
    logic [LW-1:0]            lim;
    logic [LW-1:0]            open_offset;
    logic [LW-1:0]            rem;
    logic [LW-1:0]            open_chunk;
    logic                     open_done;
    logic [LW-1:0]            mem_idx;
    logic [LW-1:0]            pos_inc;
    logic                     is_ack;

    // an item is carried out when the result register is free or being drained
    assign fire     = item_valid && (!out_valid_reg || !out_stall);
    assign item_pop = fire;

    // packet opening, shared by the open response and the acknowledgement
    always_comb
    begin
        at_rest     = (state_reg == S_IDLE) || (state_reg == S_OK) || (state_reg == S_FAILED);
        len_eff     = (cfg.payload_length > LEN_CAP) ? LEN_CAP : cfg.payload_length;
        lim         = (cfg.max_chunk == '0) ? LW'(1) : cfg.max_chunk;
        is_ack      = (state_reg == S_WAIT_ACK) && (item.data == cfus_pkg::RSP_ACK);
        open_offset = is_ack ? (send_offset_reg + chunk_reg) : send_offset_reg;
        open_done   = (open_offset >= len_eff);
        rem         = len_eff - open_offset;
        open_chunk  = (rem > lim) ? lim : rem;
        mem_idx     = send_offset_reg + byte_pos_reg;
        pos_inc     = byte_pos_reg + LW'(1);
        mem_rd_addr = mem_idx[AW-1:0];
    end

    // next state for the item at the head of the queue
    always_comb
    begin
        state_next       = state_reg;
        load_count_next  = load_count_reg;
        packet_id_next   = packet_id_reg;
        send_offset_next = send_offset_reg;
        byte_pos_next    = byte_pos_reg;
        chunk_next       = chunk_reg;
        error_next       = error_reg;
        tx_valid_next    = 1'b0;
        tx_byte_next     = 8'h00;
        use_mem_next     = 1'b0;
        mem_wr           = 1'b0;
        mem_rd           = 1'b0;

        unique case (item.cmd)
            cfus_pkg::CMD_LOAD:
            begin
                if (at_rest && (load_count_reg < LEN_CAP))
                begin
                    mem_wr          = 1'b1;
                    load_count_next = load_count_reg + LW'(1);
                end
            end
            cfus_pkg::CMD_START:
            begin
                if (at_rest)
                begin
                    packet_id_next   = '0;
                    send_offset_next = '0;
                    byte_pos_next    = '0;
                    chunk_next       = '0;
                    error_next       = cfus_pkg::ERR_NONE;
                    state_next       = S_WAIT_OPEN;
                end
            end
            cfus_pkg::CMD_SLOT:
            begin
                if (state_reg == S_HEADER)
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = cfus_pkg::header_byte(byte_pos_reg[3:0], packet_id_reg,
                                                          chunk_reg);
                    byte_pos_next = pos_inc;
                    if (pos_inc >= HDR_LEN)
                    begin
                        byte_pos_next = '0;
                        state_next    = (chunk_reg == '0) ? S_WAIT_ACK : S_DATA;
                    end
                end
                else if (state_reg == S_DATA)
                begin
                    tx_valid_next = 1'b1;
                    use_mem_next  = (mem_idx < LEN_CAP);
                    mem_rd        = 1'b1;
                    byte_pos_next = pos_inc;
                    if (pos_inc >= chunk_reg)
                    begin
                        byte_pos_next = '0;
                        state_next    = S_WAIT_ACK;
                    end
                end
            end
            cfus_pkg::CMD_RESP:
            begin
                if (state_reg == S_WAIT_OPEN)
                begin
                    if (item.data == cfus_pkg::RSP_OPEN)
                    begin
                        if (open_done)
                        begin
                            state_next = S_WAIT_FINAL;
                        end
                        else
                        begin
                            chunk_next    = open_chunk;
                            byte_pos_next = '0;
                            state_next    = S_HEADER;
                        end
                    end
                    else if (item.data == cfus_pkg::RSP_CREATE_F)
                    begin
                        state_next = S_FAILED;
                        error_next = cfus_pkg::ERR_CREATE;
                    end
                    else
                    begin
                        state_next = S_FAILED;
                        error_next = cfus_pkg::ERR_UNEXPECTED;
                    end
                end
                else if (state_reg == S_WAIT_ACK)
                begin
                    if (item.data == cfus_pkg::RSP_NAK)
                    begin
                        byte_pos_next = '0;
                        state_next    = S_HEADER;
                    end
                    else if (item.data == cfus_pkg::RSP_DONE)
                    begin
                        send_offset_next = len_eff;
                        state_next       = S_WAIT_FINAL;
                    end
                    else if (is_ack)
                    begin
                        send_offset_next = open_offset;
                        packet_id_next   = packet_id_reg + 16'd1;
                        if (open_done)
                        begin
                            state_next = S_WAIT_FINAL;
                        end
                        else
                        begin
                            chunk_next    = open_chunk;
                            byte_pos_next = '0;
                            state_next    = S_HEADER;
                        end
                    end
                    else
                    begin
                        state_next = S_FAILED;
                        error_next = cfus_pkg::ERR_BAD_ACK;
                    end
                end
                else if (state_reg == S_WAIT_FINAL)
                begin
                    if (item.data == cfus_pkg::RSP_DONE)
                    begin
                        state_next = S_OK;
                    end
                    else
                    begin
                        state_next = S_FAILED;
                        error_next = cfus_pkg::ERR_COMPLETION;
                    end
                end
            end
            cfus_pkg::CMD_TIMEOUT:
            begin
                if (state_reg == S_WAIT_OPEN)
                begin
                    state_next = S_FAILED;
                    error_next = cfus_pkg::ERR_NO_RESPONSE;
                end
                else if (state_reg == S_WAIT_ACK)
                begin
                    state_next = S_FAILED;
                    error_next = cfus_pkg::ERR_PKT_TIMEOUT;
                end
                else if (state_reg == S_WAIT_FINAL)
                begin
                    state_next = S_FAILED;
                    error_next = cfus_pkg::ERR_COMPLETION;
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            load_count_reg  <= '0;
            packet_id_reg   <= '0;
            send_offset_reg <= '0;
            byte_pos_reg    <= '0;
            chunk_reg       <= '0;
            error_reg       <= cfus_pkg::ERR_NONE;
            tx_valid_reg    <= 1'b0;
            tx_byte_reg     <= 8'h00;
            use_mem_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg       <= state_next;
                load_count_reg  <= load_count_next;
                packet_id_reg   <= packet_id_next;
                send_offset_reg <= send_offset_next;
                byte_pos_reg    <= byte_pos_next;
                chunk_reg       <= chunk_next;
                error_reg       <= error_next;
                tx_valid_reg    <= tx_valid_next;
                tx_byte_reg     <= tx_byte_next;
                use_mem_reg     <= use_mem_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload buffer, read data held until the next data slot
    always_ff @(posedge clk)
    begin
        if (fire && mem_wr)
        begin
            mem[load_count_reg[AW-1:0]] <= item.data;
        end
        if (fire && mem_rd)
        begin
            mem_q_reg <= mem[mem_rd_addr];
        end
    end

    // result ports
    assign out_valid     = out_valid_reg;
    assign tx_valid      = tx_valid_reg;
    assign tx_byte       = use_mem_reg ? mem_q_reg : tx_byte_reg;
    assign phase         = state_reg;
    assign error_code    = error_reg;
    assign packet_number = packet_id_reg;
    assign bytes_acked   = send_offset_reg;
    assign finished      = (state_reg == S_OK) || (state_reg == S_FAILED);

endmodule

[sv/chunked_file_upload_sender_core.sv]
`timescale 1ns / 1ps

// Stop-and-wait file upload sender. Every transfer on the input channel gives
// exactly one transfer on the output channel, in order. The front end takes an
// input transfer into a two-entry queue; the back end carries out one queued
// item per cycle whenever its result register is free or being drained, so
// the sustained rate is one item per clock. A result passes through the queue
// and then the result register before it is offered. The payload buffer is a
// 4096 x 8 single-port memory with registered read data; data bytes of a
// packet come straight from it. The configuration registers are read live, so
// write them only while no transfer is in flight.

module chunked_file_upload_sender_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          wr_index,
    input  logic [cfus_pkg::LEN_W-1:0]    wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    req_type,
    input  logic [7:0]                    data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          tx_valid,
    output logic [7:0]                    tx_byte,
    output logic [2:0]                    phase,
    output logic [2:0]                    error_code,
    output logic [cfus_pkg::ID_W-1:0]     packet_number,
    output logic [cfus_pkg::LEN_W-1:0]    bytes_acked,
    output logic                          finished
);

    cfus_pkg::cfg_t  cfg_reg;
    logic            item_valid;
    cfus_pkg::item_t item;
    logic            item_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_length <= '0;
            cfg_reg.max_chunk      <= cfus_pkg::MAX_CHUNK_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                cfus_pkg::REG_PAYLOAD_LENGTH: cfg_reg.payload_length <= wr_data;
                cfus_pkg::REG_MAX_CHUNK:      cfg_reg.max_chunk      <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // request intake and queue
    cfus_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // transfer sequencer and payload buffer
    cfus_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .phase         (phase),
        .error_code    (error_code),
        .packet_number (packet_number),
        .bytes_acked   (bytes_acked),
        .finished      (finished)
    );

    // a byte on the link only ever leaves the block in a sending phase
    a_tx_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_valid) |-> (phase == cfus_pkg::PH_HEADER ||
                                     phase == cfus_pkg::PH_DATA ||
                                     phase == cfus_pkg::PH_WAIT_ACK))
        else $error("tx byte outside a sending phase");

    // a successful end carries no error
    a_ok_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && phase == cfus_pkg::PH_OK) |-> (error_code == cfus_pkg::ERR_NONE))
        else $error("ok phase with an error code");

    // a failed end always names its reason
    a_fail_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && phase == cfus_pkg::PH_FAILED) |-> (error_code != cfus_pkg::ERR_NONE))
        else $error("failed phase without an error code");

    // the ended flag tracks the two end phases
    a_finished: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (finished == (phase == cfus_pkg::PH_OK || phase == cfus_pkg::PH_FAILED)))
        else $error("finished flag out of step with phase");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int CLK_PERIOD    = 10;
    localparam int IDLE_PCT      = 8;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int QUIET_FROM    = 300;
    localparam int QUIET_TO      = 650;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    localparam int STUCK_LIMIT   = 1000;
    localparam int PRINT_LIMIT   = 50;
    localparam int REG_MAX_VALUE = (1 << cfus_pkg::LEN_W) - 1;

    // request codes the block does not define
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    // constant lead of every packet header, first byte on the left
    localparam logic [55:0] HDR_SYNC = 56'h3AA1BB447FFFFE;

    typedef struct packed {
        logic                       tx_valid;
        logic [7:0]                 tx_byte;
        logic [2:0]                 phase;
        logic [2:0]                 error_code;
        logic [cfus_pkg::ID_W-1:0]  packet_number;
        logic [cfus_pkg::LEN_W-1:0] bytes_acked;
        logic                       finished;
    } upload_status_t;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       wr_en      = 1'b0;
    logic                       wr_index   = 1'b0;
    logic [cfus_pkg::LEN_W-1:0] wr_data    = '0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic [2:0]                 req_type   = cfus_pkg::REQ_LOAD;
    logic [7:0]                 data_byte  = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic                       tx_valid;
    logic [7:0]                 tx_byte;
    logic [2:0]                 phase;
    logic [2:0]                 error_code;
    logic [cfus_pkg::ID_W-1:0]  packet_number;
    logic [cfus_pkg::LEN_W-1:0] bytes_acked;
    logic                       finished;

    // shadow copy of the sender state
    logic [7:0]                 shadow_buf [cfus_pkg::PAYLOAD_MAX];
    int unsigned                sh_loaded  = 0;
    logic [2:0]                 sh_phase   = cfus_pkg::PH_IDLE;
    logic [2:0]                 sh_error   = cfus_pkg::ERR_NONE;
    logic [cfus_pkg::ID_W-1:0]  sh_pkt_id  = '0;
    int unsigned                sh_offset  = 0;
    int unsigned                sh_pos     = 0;
    int unsigned                sh_chunk   = 0;
    int unsigned                cfg_length = 0;
    int unsigned                cfg_chunk  = cfus_pkg::MAX_CHUNK_RESET;

    upload_status_t   expected_status [$];
    upload_status_t   want;
    int unsigned      accepted     = 0;
    int unsigned      results_seen = 0;
    int unsigned      mismatches   = 0;
    int unsigned      stuck_cycles = 0;
    bit               quiet        = 1'b0;

    chunked_file_upload_sender_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .phase         (phase),
        .error_code    (error_code),
        .packet_number (packet_number),
        .bytes_acked   (bytes_acked),
        .finished      (finished)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic bit at_rest();
        return sh_phase == cfus_pkg::PH_IDLE || sh_phase == cfus_pkg::PH_OK ||
               sh_phase == cfus_pkg::PH_FAILED;
    endfunction

    function automatic int unsigned eff_length();
        return cfg_length > cfus_pkg::PAYLOAD_MAX ? cfus_pkg::PAYLOAD_MAX : cfg_length;
    endfunction

    function automatic int unsigned chunk_limit();
        return cfg_chunk == 0 ? 1 : cfg_chunk;
    endfunction

    // next packet from the current offset, or the final wait once all is sent
    function automatic void begin_packet();
        int unsigned rest;
        if (sh_offset >= eff_length())
        begin
            sh_phase = cfus_pkg::PH_WAIT_FINAL;
        end
        else
        begin
            rest     = eff_length() - sh_offset;
            sh_chunk = rest > chunk_limit() ? chunk_limit() : rest;
            sh_pos   = 0;
            sh_phase = cfus_pkg::PH_HEADER;
        end
    endfunction

    function automatic logic [7:0] header_at(int unsigned p);
        logic [7:0] b;
        if (p < 7)
            b = HDR_SYNC[8 * (6 - p) +: 8];
        else if (p == 7)
            b = 8'h00;
        else if (p == 8)
            b = sh_pkt_id[7:0];
        else if (p == 9)
            b = sh_pkt_id[15:8];
        else if (p == 10)
            b = 8'(sh_chunk);
        else
            b = 8'(sh_chunk >> 8);
        return b;
    endfunction

    function automatic void fail_upload(logic [2:0] code);
        sh_phase = cfus_pkg::PH_FAILED;
        sh_error = code;
    endfunction

    // apply one event to the shadow state and give the status it produces
    function automatic upload_status_t advance_sender(logic [2:0] req, logic [7:0] db);
        upload_status_t r;
        bit             rest_now;
        int unsigned    idx;
        r        = '0;
        rest_now = at_rest();
        case (req)
            cfus_pkg::REQ_LOAD:
            begin
                if (rest_now && sh_loaded < cfus_pkg::PAYLOAD_MAX)
                begin
                    shadow_buf[sh_loaded] = db;
                    sh_loaded++;
                end
            end
            cfus_pkg::REQ_START:
            begin
                if (rest_now)
                begin
                    sh_pkt_id = '0;
                    sh_offset = 0;
                    sh_pos    = 0;
                    sh_chunk  = 0;
                    sh_error  = cfus_pkg::ERR_NONE;
                    sh_phase  = cfus_pkg::PH_WAIT_OPEN;
                end
            end
            cfus_pkg::REQ_SLOT:
            begin
                if (sh_phase == cfus_pkg::PH_HEADER)
                begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = header_at(sh_pos);
                    sh_pos++;
                    if (sh_pos >= cfus_pkg::HEADER_BYTES)
                    begin
                        sh_pos   = 0;
                        sh_phase = sh_chunk == 0 ? cfus_pkg::PH_WAIT_ACK : cfus_pkg::PH_DATA;
                    end
                end
                else if (sh_phase == cfus_pkg::PH_DATA)
                begin
                    idx        = sh_offset + sh_pos;
                    r.tx_valid = 1'b1;
                    r.tx_byte  = idx < cfus_pkg::PAYLOAD_MAX ? shadow_buf[idx] : 8'h00;
                    sh_pos++;
                    if (sh_pos >= sh_chunk)
                    begin
                        sh_pos   = 0;
                        sh_phase = cfus_pkg::PH_WAIT_ACK;
                    end
                end
            end
            cfus_pkg::REQ_RESP:
            begin
                if (sh_phase == cfus_pkg::PH_WAIT_OPEN)
                begin
                    if (db == cfus_pkg::RSP_OPEN)
                        begin_packet();
                    else if (db == cfus_pkg::RSP_CREATE_F)
                        fail_upload(cfus_pkg::ERR_CREATE);
                    else
                        fail_upload(cfus_pkg::ERR_UNEXPECTED);
                end
                else if (sh_phase == cfus_pkg::PH_WAIT_ACK)
                begin
                    if (db == cfus_pkg::RSP_NAK)
                    begin
                        sh_pos   = 0;
                        sh_phase = cfus_pkg::PH_HEADER;
                    end
                    else if (db == cfus_pkg::RSP_DONE)
                    begin
                        sh_offset = eff_length();
                        sh_phase  = cfus_pkg::PH_WAIT_FINAL;
                    end
                    else if (db == cfus_pkg::RSP_ACK)
                    begin
                        sh_offset += sh_chunk;
                        sh_pkt_id  = sh_pkt_id + 1'b1;
                        begin_packet();
                    end
                    else
                    begin
                        fail_upload(cfus_pkg::ERR_BAD_ACK);
                    end
                end
                else if (sh_phase == cfus_pkg::PH_WAIT_FINAL)
                begin
                    if (db == cfus_pkg::RSP_DONE)
                        sh_phase = cfus_pkg::PH_OK;
                    else
                        fail_upload(cfus_pkg::ERR_COMPLETION);
                end
            end
            cfus_pkg::REQ_TIMEOUT:
            begin
                if (sh_phase == cfus_pkg::PH_WAIT_OPEN)
                    fail_upload(cfus_pkg::ERR_NO_RESPONSE);
                else if (sh_phase == cfus_pkg::PH_WAIT_ACK)
                    fail_upload(cfus_pkg::ERR_PKT_TIMEOUT);
                else if (sh_phase == cfus_pkg::PH_WAIT_FINAL)
                    fail_upload(cfus_pkg::ERR_COMPLETION);
            end
            default: ;
        endcase
        r.phase         = sh_phase;
        r.error_code    = sh_error;
        r.packet_number = sh_pkt_id;
        r.bytes_acked   = cfus_pkg::LEN_W'(sh_offset);
        r.finished      = sh_phase == cfus_pkg::PH_OK || sh_phase == cfus_pkg::PH_FAILED;
        return r;
    endfunction

    // a packet opened at this offset only reads bytes that were loaded
    function automatic bit packet_fits(int unsigned start);
        int unsigned rest;
        int unsigned n;
        if (start >= eff_length())
            return 1'b1;
        rest = eff_length() - start;
        n    = rest > chunk_limit() ? chunk_limit() : rest;
        return start + n <= sh_loaded;
    endfunction

    // ---------------------------------------------------------------- driving

    // one input transfer, with an occasional gap in front of it
    task automatic send_item(logic [2:0] req, logic [7:0] db);
        @(negedge clk);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        data_byte <= db;
        do
            @(posedge clk);
        while (in_stall);
        expected_status.push_back(advance_sender(req, db));
        accepted++;
    endtask

    // stop sending and let every outstanding result arrive
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic idx, int unsigned value);
        wait_drained();
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= cfus_pkg::LEN_W'(value);
        @(negedge clk);
        wr_en    <= 1'b0;
        if (idx == cfus_pkg::REG_PAYLOAD_LENGTH)
            cfg_length = value & REG_MAX_VALUE;
        else
            cfg_chunk = value & REG_MAX_VALUE;
    endtask

    // pick the next event of an upload in progress; clean keeps it on the happy path
    task automatic next_event(bit clean);
        logic [2:0]  req;
        logic [7:0]  db;
        int unsigned roll;
        roll = clean ? 0 : $urandom_range(99);
        req  = cfus_pkg::REQ_RESP;
        db   = 8'($urandom());
        case (sh_phase)
            cfus_pkg::PH_WAIT_OPEN:
            begin
                if (roll < 85)
                    db = cfus_pkg::RSP_OPEN;
                else if (roll < 90)
                    db = cfus_pkg::RSP_CREATE_F;
                else if (roll < 95)
                    req = cfus_pkg::REQ_TIMEOUT;
            end
            cfus_pkg::PH_HEADER, cfus_pkg::PH_DATA:
            begin
                if (roll < 92)
                    req = cfus_pkg::REQ_SLOT;
                else
                    req = 3'($urandom_range(REQ_UNUSED_HI));
            end
            cfus_pkg::PH_WAIT_ACK:
            begin
                if (roll < 70)
                    db = cfus_pkg::RSP_ACK;
                else if (roll < 82)
                    db = cfus_pkg::RSP_NAK;
                else if (roll < 87)
                    db = cfus_pkg::RSP_DONE;
                else if (roll < 91)
                    req = cfus_pkg::REQ_TIMEOUT;
                else if (roll >= 95)
                    req = 3'($urandom_range(REQ_UNUSED_HI));
            end
            cfus_pkg::PH_WAIT_FINAL:
            begin
                if (roll < 85)
                    db = cfus_pkg::RSP_DONE;
                else if (roll < 90)
                    req = cfus_pkg::REQ_TIMEOUT;
                else if (roll >= 95)
                    req = 3'($urandom_range(REQ_UNUSED_HI));
            end
            default: req = cfus_pkg::REQ_START;
        endcase
        // never open a packet that would read past the loaded data
        if (req == cfus_pkg::REQ_RESP)
        begin
            if (sh_phase == cfus_pkg::PH_WAIT_OPEN && db == cfus_pkg::RSP_OPEN &&
                !packet_fits(0))
                db = cfus_pkg::RSP_CREATE_F;
            if (sh_phase == cfus_pkg::PH_WAIT_ACK && db == cfus_pkg::RSP_ACK &&
                !packet_fits(sh_offset + sh_chunk))
                db = cfus_pkg::RSP_DONE;
        end
        send_item(req, db);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report(string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    // compare each output transfer with the oldest expected status
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                report("output transfer with no status expected");
            end
            else
            begin
                want = expected_status.pop_front();
                if (tx_valid !== want.tx_valid)
                    report($sformatf("tx_valid %b, expected %b", tx_valid, want.tx_valid));
                if (tx_byte !== want.tx_byte)
                    report($sformatf("tx_byte %h, expected %h", tx_byte, want.tx_byte));
                if (phase !== want.phase)
                    report($sformatf("phase %0d, expected %0d", phase, want.phase));
                if (error_code !== want.error_code)
                    report($sformatf("error_code %0d, expected %0d",
                                     error_code, want.error_code));
                if (packet_number !== want.packet_number)
                    report($sformatf("packet_number %0d, expected %0d",
                                     packet_number, want.packet_number));
                if (bytes_acked !== want.bytes_acked)
                    report($sformatf("bytes_acked %0d, expected %0d",
                                     bytes_acked, want.bytes_acked));
                if (finished !== want.finished)
                    report($sformatf("finished %b, expected %b", finished, want.finished));
            end
            results_seen++;
        end
    end

    // receiver stalls at random
    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // events that mean nothing while idle
    task automatic test_idle_events();
        send_item(cfus_pkg::REQ_SLOT, 8'h00);
        send_item(cfus_pkg::REQ_RESP, cfus_pkg::RSP_DONE);
        send_item(cfus_pkg::REQ_TIMEOUT, 8'h00);
        send_item(REQ_UNUSED_LO, 8'hFF);
        send_item(REQ_UNUSED_HI, 8'h00);
    endtask

    // every way the opening handshake can go wrong, and a start while busy
    task automatic test_open_failures();
        send_item(cfus_pkg::REQ_START, 8'h00);
        send_item(cfus_pkg::REQ_RESP, cfus_pkg::RSP_CREATE_F);
        send_item(cfus_pkg::REQ_START, 8'hFF);
        send_item(cfus_pkg::REQ_START, 8'h00);
        send_item(cfus_pkg::REQ_TIMEOUT, 8'h00);
        send_item(cfus_pkg::REQ_START, 8'h00);
        send_item(cfus_pkg::REQ_RESP, cfus_pkg::RSP_ACK);
    endtask

    // no payload: straight from the open to the final wait
    task automatic test_empty_payload();
        send_item(cfus_pkg::REQ_LOAD, 8'h00);
        send_item(cfus_pkg::REQ_LOAD, 8'hFF);
        send_item(cfus_pkg::REQ_LOAD, 8'h55);
        send_item(cfus_pkg::REQ_LOAD, 8'hAA);
        set_reg(cfus_pkg::REG_PAYLOAD_LENGTH, 0);
        send_item(cfus_pkg::REQ_START, 8'h00);
        send_item(cfus_pkg::REQ_RESP, cfus_pkg::RSP_OPEN);
        send_item(cfus_pkg::REQ_RESP, cfus_pkg::RSP_DONE);
    endtask

    // one upload with random settings, noise and broken responses
    task automatic random_upload();
        int unsigned n_load;
        int unsigned len;
        int unsigned mc;
        int unsigned pick;
        n_load = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(40);
        repeat (n_load) send_item(cfus_pkg::REQ_LOAD, 8'($urandom()));
        pick = $urandom_range(9);
        if (pick == 0)
            len = 0;
        else if (pick == 1)
            len = sh_loaded > 256 ? 256 : sh_loaded;
        else if (pick == 2)
            len = $urandom_range(REG_MAX_VALUE);
        else
            len = $urandom_range(sh_loaded < 48 ? sh_loaded : 48);
        case ($urandom_range(9))
            0:       mc = 0;
            1:       mc = 1;
            2:       mc = REG_MAX_VALUE;
            3:       mc = cfus_pkg::PAYLOAD_MAX;
            default: mc = $urandom_range(1, 16);
        endcase
        // long settings go with big chunks to keep the packet count down
        if (pick == 2)
            mc = $urandom_range(256, REG_MAX_VALUE);
        if (pick == 1 && mc < 32)
            mc = 32;
        set_reg(cfus_pkg::REG_PAYLOAD_LENGTH, len);
        set_reg(cfus_pkg::REG_MAX_CHUNK, mc);
        if ($urandom_range(3) == 0)
            send_item(3'($urandom_range(REQ_UNUSED_HI)), 8'($urandom()));
        if (at_rest())
            send_item(cfus_pkg::REQ_START, 8'($urandom()));
        while (!at_rest())
            next_event(1'b0);
    endtask

    task automatic test_random_uploads();
        int unsigned first;
        first = accepted;
        while (accepted - first < RANDOM_ITEMS)
        begin
            quiet = (accepted - first >= QUIET_FROM) && (accepted - first < QUIET_TO);
            random_upload();
        end
        quiet = 1'b0;
    endtask

    // a length above the buffer size is clamped in the completion offset
    task automatic test_length_clamp();
        set_reg(cfus_pkg::REG_PAYLOAD_LENGTH, REG_MAX_VALUE);
        set_reg(cfus_pkg::REG_MAX_CHUNK, 1);
        send_item(cfus_pkg::REQ_START, 8'h00);
        send_item(cfus_pkg::REQ_RESP, cfus_pkg::RSP_OPEN);
        repeat (cfus_pkg::HEADER_BYTES + 1) send_item(cfus_pkg::REQ_SLOT, 8'h00);
        send_item(cfus_pkg::REQ_RESP, cfus_pkg::RSP_NAK);
        repeat (cfus_pkg::HEADER_BYTES + 1) send_item(cfus_pkg::REQ_SLOT, 8'h00);
        send_item(cfus_pkg::REQ_RESP, cfus_pkg::RSP_DONE);
        send_item(cfus_pkg::REQ_RESP, cfus_pkg::RSP_DONE);
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_events();
        test_open_failures();
        test_empty_payload();
        test_random_uploads();
        test_length_clamp();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
